@@ sv/ipv4_icmp_frame_checker_assert.svh @@
// Assertion macros shared by the frame checker RTL.
`ifndef IPV4_ICMP_FRAME_CHECKER_ASSERT_SVH
`define IPV4_ICMP_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define IICFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define IICFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/iicfc_pkg.sv @@
// Constants, verdict codes, result layout and checksum helper for the frame checker.
package iicfc_pkg;

	localparam int POS_W = 11;
	localparam int MAX_FRAME_BYTES = 1600;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [15:0] SUM_GOOD = 16'hFFFF;
	localparam logic [15:0] ICMP_ECHO_REQ = 16'h0800;
	localparam logic [15:0] ICMP_ECHO_REPLY = 16'h0000;
	localparam logic [7:0] PROTO_ICMP = 8'd1;

	typedef enum logic [3:0] {
		V_ECHO_REQ = 4'd0,
		V_ECHO_REPLY = 4'd1,
		V_NOT_IPV4 = 4'd2,
		V_IP_SUM_BAD = 4'd3,
		V_NOT_ICMP = 4'd4,
		V_IP_ONLY = 4'd5,
		V_ICMP_TYPE_BAD = 4'd6,
		V_ICMP_SUM_BAD = 4'd7,
		V_ZERO_DEST = 4'd8,
		V_BAD_LENGTH = 4'd9
	} verdict_t;

	// Last member lands in the lowest bits.
	typedef struct packed {
		logic             echo_kept;
		logic [POS_W-1:0] payload_length;
		logic [15:0]      echo_sequence;
		logic [15:0]      echo_ident;
		logic [15:0]      ip_ident;
		logic [31:0]      ip_dest;
		logic [31:0]      ip_source;
		logic [47:0]      source_mac;
		logic [47:0]      dest_mac;
		verdict_t         verdict;
	} result_t;

	// Ones'-complement add with end-around carry.
	function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
		logic [16:0] s;
		logic [16:0] f;
		s = {1'b0, acc} + {1'b0, word};
		f = {1'b0, s[15:0]} + {16'd0, s[16]};
		return f[15:0];
	endfunction

endpackage

@@ sv/ipv4_icmp_frame_checker.sv @@
// Ethernet/IPv4/ICMP echo frame checker: byte parser, checksums and verdict.
// Throughput: one frame byte per clock; the input side stalls only when a final
// byte is ready while the previous result word is still waiting to be taken.
// Result: the word is registered and is valid right after the edge at which its final
// byte leaves the input register; that byte can be held there by a full result register.
// Reset: arst_n clears valid flags, byte position, sums and capture registers.
module ipv4_icmp_frame_checker
	import iicfc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // last_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [223:0] m_tdata    // verdict[3:0], dest_mac[51:4], source_mac[99:52],
	                                // ip_source[131:100], ip_dest[163:132],
	                                // ip_ident[179:164], echo_ident[195:180],
	                                // echo_sequence[211:196], payload_length[222:212],
	                                // echo_kept[223]
);

	`include "ipv4_icmp_frame_checker_assert.svh"

	localparam logic [POS_W:0] MaxBytes = (POS_W+1)'(MAX_FRAME_BYTES);
	localparam logic [POS_W-1:0] PosMax = '1;

	// Input register
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Frame state
	logic [POS_W-1:0] pos_q;
	logic [15:0] hsum_q, msum_q;
	logic [7:0]  hold_q;
	logic [47:0] dmac_q, smac_q;
	logic [15:0] etype_q;
	logic [7:0]  proto_q;
	logic [31:0] ipsrc_q, ipdst_q;
	logic [15:0] ipid_q, tc_q, eid_q, seq_q;

	// Next values
	logic [POS_W-1:0] pos_n;
	logic [15:0] hsum_n, msum_n, msum_fin;
	logic [7:0]  hold_n;
	logic [47:0] dmac_n, smac_n;
	logic [15:0] etype_n;
	logic [7:0]  proto_n;
	logic [31:0] ipsrc_n, ipdst_n;
	logic [15:0] ipid_n, tc_n, eid_n, seq_n;

	// Output register
	logic    out_valid_q;
	result_t out_q;
	result_t res;

	logic advance;
	logic in_range;
	logic pad;
	logic [15:0] word;

	// Only a final byte can wait, and only on a full output register.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	assign in_range = {1'b0, pos_q} < MaxBytes;
	assign word     = {hold_q, data_s1};
	// Odd ICMP length: final byte sits at an even position and gets a zero low byte.
	assign pad      = in_range && (pos_q >= 11'd34) && !pos_q[0];

	// Capture and running sums
	always_comb begin
		hsum_n  = hsum_q;
		msum_n  = msum_q;
		hold_n  = hold_q;
		dmac_n  = dmac_q;
		smac_n  = smac_q;
		etype_n = etype_q;
		proto_n = proto_q;
		ipsrc_n = ipsrc_q;
		ipdst_n = ipdst_q;
		ipid_n  = ipid_q;
		tc_n    = tc_q;
		eid_n   = eid_q;
		seq_n   = seq_q;
		if (in_range) begin
			if (pos_q < 11'd6) begin
				dmac_n = {dmac_q[39:0], data_s1};
			end else if (pos_q < 11'd12) begin
				smac_n = {smac_q[39:0], data_s1};
			end else if (pos_q < 11'd14) begin
				etype_n = {etype_q[7:0], data_s1};
			end else if (pos_q == 11'd18 || pos_q == 11'd19) begin
				ipid_n = {ipid_q[7:0], data_s1};
			end else if (pos_q == 11'd23) begin
				proto_n = data_s1;
			end else if (pos_q >= 11'd26 && pos_q < 11'd30) begin
				ipsrc_n = {ipsrc_q[23:0], data_s1};
			end else if (pos_q >= 11'd30 && pos_q < 11'd34) begin
				ipdst_n = {ipdst_q[23:0], data_s1};
			end else if (pos_q == 11'd34 || pos_q == 11'd35) begin
				tc_n = {tc_q[7:0], data_s1};
			end else if (pos_q == 11'd38 || pos_q == 11'd39) begin
				eid_n = {eid_q[7:0], data_s1};
			end else if (pos_q == 11'd40 || pos_q == 11'd41) begin
				seq_n = {seq_q[7:0], data_s1};
			end
			if (!pos_q[0]) begin
				hold_n = data_s1;
			end else if (pos_q >= 11'd15 && pos_q < 11'd34) begin
				hsum_n = oc_add(hsum_q, word);
			end else if (pos_q >= 11'd35) begin
				msum_n = oc_add(msum_q, word);
			end
		end
		pos_n = (pos_q == PosMax) ? pos_q : pos_q + 11'd1;
	end

	// Verdict, first failing check wins
	always_comb begin
		msum_fin = pad ? oc_add(msum_n, {data_s1, 8'h00}) : msum_n;
		res.dest_mac       = dmac_n;
		res.source_mac     = smac_n;
		res.ip_source      = ipsrc_n;
		res.ip_dest        = ipdst_n;
		res.ip_ident       = ipid_n;
		res.echo_ident     = eid_n;
		res.echo_sequence  = seq_n;
		res.payload_length = '0;
		res.echo_kept      = 1'b0;
		if (pos_q < 11'd13 || !in_range) begin
			res.verdict = V_BAD_LENGTH;
		end else if (etype_n != ETHERTYPE_IPV4) begin
			res.verdict = V_NOT_IPV4;
		end else if (pos_q < 11'd33) begin
			res.verdict = V_BAD_LENGTH;
		end else if (hsum_n != SUM_GOOD) begin
			res.verdict = V_IP_SUM_BAD;
		end else if (proto_n != PROTO_ICMP) begin
			res.verdict = V_NOT_ICMP;
		end else if (ipdst_n == 32'd0) begin
			res.verdict = V_ZERO_DEST;
		end else if (pos_q == 11'd33) begin
			res.verdict = V_IP_ONLY;
		end else if (pos_q < 11'd41) begin
			res.verdict = V_BAD_LENGTH;
		end else if (tc_n != ICMP_ECHO_REQ && tc_n != ICMP_ECHO_REPLY) begin
			res.verdict = V_ICMP_TYPE_BAD;
		end else if (msum_fin != SUM_GOOD) begin
			res.verdict = V_ICMP_SUM_BAD;
		end else begin
			res.verdict        = (tc_n == ICMP_ECHO_REQ) ? V_ECHO_REQ : V_ECHO_REPLY;
			res.payload_length = pos_q - 11'd41;
			res.echo_kept      = (pos_q != 11'd41) && (eid_n != 16'd0) && (seq_n != 16'd0);
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			data_s1  <= '0;
			last_s1  <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			data_s1  <= s_tdata;
			last_s1  <= s_tlast;
		end
	end

	// Frame state: cleared after every final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hsum_q  <= '0;
			msum_q  <= '0;
			hold_q  <= '0;
			dmac_q  <= '0;
			smac_q  <= '0;
			etype_q <= '0;
			proto_q <= '0;
			ipsrc_q <= '0;
			ipdst_q <= '0;
			ipid_q  <= '0;
			tc_q    <= '0;
			eid_q   <= '0;
			seq_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				pos_q   <= '0;
				hsum_q  <= '0;
				msum_q  <= '0;
				hold_q  <= '0;
				dmac_q  <= '0;
				smac_q  <= '0;
				etype_q <= '0;
				proto_q <= '0;
				ipsrc_q <= '0;
				ipdst_q <= '0;
				ipid_q  <= '0;
				tc_q    <= '0;
				eid_q   <= '0;
				seq_q   <= '0;
			end else begin
				pos_q   <= pos_n;
				hsum_q  <= hsum_n;
				msum_q  <= msum_n;
				hold_q  <= hold_n;
				dmac_q  <= dmac_n;
				smac_q  <= smac_n;
				etype_q <= etype_n;
				proto_q <= proto_n;
				ipsrc_q <= ipsrc_n;
				ipdst_q <= ipdst_n;
				ipid_q  <= ipid_n;
				tc_q    <= tc_n;
				eid_q   <= eid_n;
				seq_q   <= seq_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_q <= res;
		end
	end

	`IICFC_ASSERT_NOW(a_mid_frame_no_stall, clk, arst_n, valid_s1 && !last_s1, s_tready,
		"mid-frame word stalled")
	`IICFC_ASSERT_NEXT(a_final_loads_result, clk, arst_n, advance && last_s1,
		out_valid_q && pos_q == '0 && hsum_q == '0, "final word did not load result")
	`IICFC_ASSERT_NOW(a_verdict_range, clk, arst_n, out_valid_q,
		out_q.verdict <= V_BAD_LENGTH, "verdict code out of range")
	`IICFC_ASSERT_NOW(a_kept_only_echo, clk, arst_n, out_valid_q && out_q.echo_kept,
		out_q.verdict == V_ECHO_REQ || out_q.verdict == V_ECHO_REPLY,
		"echo_kept set on non-echo verdict")

endmodule
